### hw/rtl/icy_metadata_deframer_unit_assert.svh
// assertion macros shared by the deframer rtl
// no dependencies; modules that assert expect clk and rst_n in scope
`ifndef ICY_METADATA_DEFRAMER_UNIT_ASSERT_SVH
`define ICY_METADATA_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define ICYMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ICYMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ICYMD_ASSERT(lbl, prop, msg)
`define ICYMD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### hw/rtl/icymd_pkg.sv
// types and constants of the icy metadata deframer
// no dependencies
package icymd_pkg;

    localparam int INTERVAL_W = 20;
    localparam int META_LEFT_W = 12;

    localparam logic [3:0] KEY_LEN = 4'd13;
    localparam logic [7:0] CHAR_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_TITLE = 2'd1,
        KIND_EMPTY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_CLOSED  = 2'd2,
        PH_STOPPED = 2'd3
    } phase_t;

    typedef struct packed {
        logic restart;
        logic scan;
    } scan_ctrl_t;

    typedef struct packed {
        logic closed_next;
        logic empty;
    } scan_stat_t;

    typedef struct packed {
        logic start;
        logic step;
    } drain_ctrl_t;

    typedef struct packed {
        logic busy;
        logic last;
    } drain_stat_t;

    // characters of StreamTitle='
    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = 8'h53;
            4'd1:    ch = 8'h74;
            4'd2:    ch = 8'h72;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h61;
            4'd5:    ch = 8'h6d;
            4'd6:    ch = 8'h54;
            4'd7:    ch = 8'h69;
            4'd8:    ch = 8'h74;
            4'd9:    ch = 8'h6c;
            4'd10:   ch = 8'h65;
            4'd11:   ch = 8'h3d;
            4'd12:   ch = 8'h27;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/icymd_if.sv
// channel interfaces of the icy metadata deframer
// depends on icymd_pkg for field widths
interface icymd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface icymd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       title_last;

    modport source (output valid, output out_kind, output out_byte, output title_last,
                    input ready);
    modport sink (input valid, input out_kind, input out_byte, input title_last,
                  output ready);
endinterface

interface icymd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [icymd_pkg::INTERVAL_W-1:0]    meta_interval;

    modport source (output valid, output meta_interval, input ready);
    modport sink (input valid, input meta_interval, output ready);
endinterface

### hw/rtl/icymd_scan.sv
// streaming matcher for the title key and title capture
// depends on icymd_pkg
module icymd_scan #(
    parameter int TITLE_MAX = 64,
    parameter int BLOCK_MAX = 4096,
    localparam int CW = $clog2(TITLE_MAX),
    localparam int SW = $clog2(BLOCK_MAX + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  icymd_pkg::scan_ctrl_t  ctrl,
    input  logic [7:0]             data_byte,
    output icymd_pkg::scan_stat_t  stat,
    output logic [CW-1:0]          title_count,
    output logic                   wr_en,
    output logic [7:0]             wr_data
);
    import icymd_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [3:0]    match_pos_reg, match_pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] seen_reg, seen_next;
    logic          scan_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEARCH;
            match_pos_reg <= '0;
            count_reg     <= '0;
            seen_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            match_pos_reg <= match_pos_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
        end
    end

    // only the first BLOCK_MAX bytes of a block are looked at
    assign scan_en = ctrl.scan && (seen_reg < SW'(BLOCK_MAX));

    always_comb
    begin
        phase_next     = phase_reg;
        match_pos_next = match_pos_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        wr_en          = 1'b0;
        if (ctrl.restart)
        begin
            phase_next     = PH_SEARCH;
            match_pos_next = '0;
            count_next     = '0;
            seen_next      = '0;
        end
        else if (scan_en)
        begin
            seen_next = seen_reg + SW'(1);
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (data_byte == CHAR_NUL)
                    begin
                        phase_next = PH_STOPPED;
                    end
                    else if (data_byte == key_char(match_pos_reg))
                    begin
                        match_pos_next = match_pos_reg + 4'd1;
                        if (match_pos_reg == KEY_LEN - 4'd1)
                        begin
                            phase_next = PH_CAPTURE;
                        end
                    end
                    else
                    begin
                        // the head character occurs only once in the key
                        match_pos_next = (data_byte == CHAR_S) ? 4'd1 : 4'd0;
                    end
                end
                PH_CAPTURE:
                begin
                    if (data_byte == CHAR_NUL)
                    begin
                        phase_next = PH_STOPPED;
                    end
                    else if (data_byte == CHAR_QUOTE)
                    begin
                        phase_next = PH_CLOSED;
                    end
                    else if (count_reg < CW'(TITLE_MAX - 1))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                PH_CLOSED, PH_STOPPED:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign wr_data          = data_byte;
    assign title_count      = count_reg;
    assign stat.closed_next = (phase_next == PH_CLOSED);
    assign stat.empty       = (count_reg == '0);

endmodule

### hw/rtl/icymd_store.sv
// title character memory and the read side that drains a title run
// depends on icymd_pkg
module icymd_store #(
    parameter int TITLE_MAX = 64,
    localparam int CW = $clog2(TITLE_MAX),
    localparam int IW = (TITLE_MAX > 2) ? $clog2(TITLE_MAX - 1) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CW-1:0]          wr_count,
    input  logic [7:0]             wr_data,
    input  icymd_pkg::drain_ctrl_t ctrl,
    output icymd_pkg::drain_stat_t stat,
    output logic [7:0]             rd_data
);
    import icymd_pkg::*;

    logic [7:0]    mem [0:TITLE_MAX-2];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] count_m1;
    logic          last;

    // write address is the current fill count, length stays put while draining
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_count[IW-1:0]] <= wr_data;
        end
    end

    // read ahead on the next index so data lines up with rd_idx_reg
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            busy_reg   <= busy_next;
        end
    end

    assign count_m1 = wr_count - CW'(1);
    assign last     = (rd_idx_reg == count_m1[IW-1:0]);

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        busy_next   = busy_reg;
        if (ctrl.start)
        begin
            rd_idx_next = '0;
            busy_next   = 1'b1;
        end
        else if (ctrl.step)
        begin
            if (last)
            begin
                rd_idx_next = '0;
                busy_next   = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + IW'(1);
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.last = last;
    assign rd_data   = rd_data_reg;

endmodule

### hw/rtl/icy_metadata_deframer_unit.sv
// top level of the icy metadata deframer: input register, framing counters, result register
// depends on icymd_pkg, icymd_if, icymd_scan, icymd_store and the assertion header
//
//   channel      dir  fields                             role
//   stream_in    in   data_byte                          raw stream bytes
//   result_out   out  out_kind, out_byte, title_last     audio bytes and title runs
//   cfg          in   meta_interval                      interval write, always ready
//
// one byte per cycle while audio or metadata bytes flow unstalled; the input register feeds the
// framing and matcher logic and results land in a single output register.
// the block-end byte of a closed, non-empty title stalls input while the title memory is
// read out through its registered read port, one character a cycle unless result_out stalls.
// reset clears all control state; the title memory needs no clearing.
// a stall on result_out holds the output register and backs up into the input register.
`include "icy_metadata_deframer_unit_assert.svh"

module icy_metadata_deframer_unit #(
    parameter int TITLE_MAX = 64,
    parameter int BLOCK_MAX = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    icymd_in_if.sink    stream_in,
    icymd_out_if.source result_out,
    icymd_cfg_if.sink   cfg
);
    import icymd_pkg::*;

    localparam int CW = $clog2(TITLE_MAX);

    logic [INTERVAL_W-1:0]  interval_reg, interval_next;
    logic [INTERVAL_W-1:0]  audio_left_reg, audio_left_next;
    logic [META_LEFT_W-1:0] meta_left_reg, meta_left_next;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    logic       out_valid_reg, out_valid_next;
    kind_t      out_kind_reg, out_kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    logic        cfg_we, in_accept, slot_free, proc_fire;
    logic        is_audio, is_length, is_meta, block_end;
    logic        res_valid;
    kind_t       res_kind;
    logic [7:0]  res_byte;
    logic        res_last;

    scan_ctrl_t    scan_ctrl;
    scan_stat_t    scan_stat;
    drain_ctrl_t   drain_ctrl;
    drain_stat_t   drain_stat;
    logic [CW-1:0] title_count;
    logic          wr_en;
    logic [7:0]    wr_data;
    logic [7:0]    rd_data;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    assign slot_free       = !out_valid_reg || result_out.ready;
    assign proc_fire       = in_valid_reg && !drain_stat.busy && slot_free;
    assign stream_in.ready = !in_valid_reg || proc_fire;
    assign in_accept       = stream_in.valid && stream_in.ready;

    assign is_audio  = (interval_reg == '0) || (audio_left_reg != '0);
    assign is_length = !is_audio && (meta_left_reg == '0);
    assign is_meta   = !is_audio && (meta_left_reg != '0);
    assign block_end = is_meta && (meta_left_reg == META_LEFT_W'(1));

    assign scan_ctrl.restart = cfg_we || (proc_fire && is_length);
    assign scan_ctrl.scan    = proc_fire && is_meta;

    assign drain_ctrl.start = proc_fire && block_end && scan_stat.closed_next
                              && !scan_stat.empty;
    assign drain_ctrl.step  = drain_stat.busy && slot_free;

    icymd_scan #(
        .TITLE_MAX(TITLE_MAX),
        .BLOCK_MAX(BLOCK_MAX)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (scan_ctrl),
        .data_byte   (in_byte_reg),
        .stat        (scan_stat),
        .title_count (title_count),
        .wr_en       (wr_en),
        .wr_data     (wr_data)
    );

    icymd_store #(
        .TITLE_MAX(TITLE_MAX)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_count (title_count),
        .wr_data  (wr_data),
        .ctrl     (drain_ctrl),
        .stat     (drain_stat),
        .rd_data  (rd_data)
    );

    // framing counters and the result of the byte in the input register
    always_comb
    begin
        interval_next   = interval_reg;
        audio_left_next = audio_left_reg;
        meta_left_next  = meta_left_reg;
        res_valid       = 1'b0;
        res_kind        = KIND_AUDIO;
        res_byte        = in_byte_reg;
        res_last        = 1'b0;
        if (cfg_we)
        begin
            interval_next   = cfg.meta_interval;
            audio_left_next = cfg.meta_interval;
            meta_left_next  = '0;
        end
        else if (proc_fire)
        begin
            priority if (is_audio)
            begin
                res_valid = 1'b1;
                if (interval_reg != '0)
                begin
                    audio_left_next = audio_left_reg - INTERVAL_W'(1);
                end
            end
            else if (is_length)
            begin
                meta_left_next = {in_byte_reg, 4'b0000};
                if (in_byte_reg == 8'h00)
                begin
                    audio_left_next = interval_reg;
                end
            end
            else
            begin
                meta_left_next = meta_left_reg - META_LEFT_W'(1);
                if (block_end)
                begin
                    audio_left_next = interval_reg;
                    if (scan_stat.closed_next && scan_stat.empty)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_EMPTY;
                        res_byte  = 8'h00;
                        res_last  = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (drain_ctrl.step)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_TITLE;
            out_byte_next  = rd_data;
            out_last_next  = drain_stat.last;
        end
        else if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind;
            out_byte_next  = res_byte;
            out_last_next  = res_last;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= '0;
            audio_left_reg <= '0;
            meta_left_reg  <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            interval_reg   <= interval_next;
            audio_left_reg <= audio_left_next;
            meta_left_reg  <= meta_left_next;
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= stream_in.data_byte;
        end
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.out_kind   = out_kind_reg;
    assign result_out.out_byte   = out_byte_reg;
    assign result_out.title_last = out_last_reg;

    `ICYMD_ASSERT(a_meta_excludes_audio, (meta_left_reg != '0) |-> (audio_left_reg == '0), "metadata block open while audio bytes remain")
    `ICYMD_ASSERT(a_drain_starts, drain_ctrl.start |=> drain_stat.busy, "title run did not start draining")
    `ICYMD_ASSERT(a_drain_ends, (drain_ctrl.step && drain_stat.last) |=> !drain_stat.busy, "title run kept draining after its last character")
    `ICYMD_ASSERT(a_marker_last, (out_valid_reg && (out_kind_reg == KIND_EMPTY)) |-> out_last_reg, "empty title marker without last flag")
    `ICYMD_ASSERT(a_no_input_in_drain, drain_stat.busy |-> !scan_ctrl.scan, "input byte processed during a title run")

endmodule
